// ----- sv/aeba_pkg.sv -----
// Shared types, constants and the sequencer microcode of the encoder block averager.
package aeba_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLES_DEF     = 17;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths of the channels and registers.
    localparam int SAMPLE_W   = 12;
    localparam int MEAN_W     = 12;
    localparam int POS_W      = 32;
    localparam int DIVIDED_W  = 16;
    localparam int TPT_W      = 32;
    localparam int TDIV_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_TURN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDER   = 2'd1;

    // Register values after reset.
    localparam logic [TPT_W-1:0]  TPT_RESET  = 32'd4096;
    localparam logic [TDIV_W-1:0] TDIV_RESET = 8'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [MEAN_W-1:0]    mean_sample;
        logic [POS_W-1:0]     position_ticks;
        logic [DIVIDED_W-1:0] divided_ticks;
    } t_out;

    // Microcode: step counter width, datapath actions and jump conditions.
    localparam int PC_W = 3;

    localparam logic [2:0] A_NONE       = 3'd0;
    localparam logic [2:0] A_MEAN_MUL   = 3'd1;
    localparam logic [2:0] A_DIV_STEP   = 3'd2;
    localparam logic [2:0] A_STORE_MEAN = 3'd3;
    localparam logic [2:0] A_MUL        = 3'd4;
    localparam logic [2:0] A_LOAD_POS   = 3'd5;
    localparam logic [2:0] A_EMIT       = 3'd6;

    localparam logic [1:0] C_NEXT     = 2'd0;
    localparam logic [1:0] C_NO_START = 2'd1;
    localparam logic [1:0] C_ITER     = 2'd2;
    localparam logic [1:0] C_OUT_FULL = 2'd3;

    localparam logic [PC_W-1:0] PC_IDLE       = 3'd0;
    localparam logic [PC_W-1:0] PC_MEAN_MUL   = 3'd1;
    localparam logic [PC_W-1:0] PC_STORE_MEAN = 3'd2;
    localparam logic [PC_W-1:0] PC_MUL        = 3'd3;
    localparam logic [PC_W-1:0] PC_LOAD_POS   = 3'd4;
    localparam logic [PC_W-1:0] PC_DIV_POS    = 3'd5;
    localparam logic [PC_W-1:0] PC_WAIT_OUT   = 3'd6;
    localparam logic [PC_W-1:0] PC_EMIT       = 3'd7;

    typedef struct packed {
        logic [2:0]      act;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } t_uop;

    // When the condition holds the sequencer jumps to target, else it steps on.
    // The step after the last one wraps to the idle step.
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            PC_IDLE:       u = '{act: A_NONE,       cond: C_NO_START, target: PC_IDLE};
            PC_MEAN_MUL:   u = '{act: A_MEAN_MUL,   cond: C_NEXT,     target: PC_IDLE};
            PC_STORE_MEAN: u = '{act: A_STORE_MEAN, cond: C_NEXT,     target: PC_IDLE};
            PC_MUL:        u = '{act: A_MUL,        cond: C_NEXT,     target: PC_IDLE};
            PC_LOAD_POS:   u = '{act: A_LOAD_POS,   cond: C_NEXT,     target: PC_IDLE};
            PC_DIV_POS:    u = '{act: A_DIV_STEP,   cond: C_ITER,     target: PC_DIV_POS};
            PC_WAIT_OUT:   u = '{act: A_NONE,       cond: C_OUT_FULL, target: PC_WAIT_OUT};
            PC_EMIT:       u = '{act: A_EMIT,       cond: C_NEXT,     target: PC_IDLE};
            default:       u = '{act: A_NONE,       cond: C_NEXT,     target: PC_IDLE};
        endcase
        return u;
    endfunction

endpackage

// ----- sv/aeba_stream_if.sv -----
// Valid/ready stream interface that carries one payload per transaction.
interface aeba_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/analog_encoder_block_average.sv -----
// Top level of the encoder block averager: sample accumulator and microcoded result sequencer.

// Each input transaction carries one ADC sample; SAMPLES samples form a block, and
// the last sample of a block produces one output transaction with the truncated
// block mean, the position in ticks (mean * ticks_per_turn >> SAMPLE_BITS, taken
// from the full-width product) and the position divided by tick_divider, wrapped
// to 16 bits (all ones when the divider is zero). A sample that does not end a
// block leaves the input ready. The sample that ends a block starts a short
// program in a microcode ROM that runs the end-of-block arithmetic: the mean
// comes from a multiplication of the block sum by a constant reciprocal and a
// shift, and the division by tick_divider runs on a restoring divider, one
// quotient bit per cycle. The steps are: reciprocal multiply, store mean,
// multiply, load, 32 divide steps, a wait for a free output register, emit.
// The input is not ready while the program runs, so the next sample is taken
// only once the sequencer has wrapped back to the idle step. The wait step
// holds while an earlier result has not been taken; samples of the next block
// are taken while a finished result waits at the output. Register writes take
// effect for the block that ends next and should be made while the sequencer is
// idle.
module analog_encoder_block_average #(
    parameter int SAMPLES     = aeba_pkg::SAMPLES_DEF,
    parameter int SAMPLE_BITS = aeba_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [aeba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aeba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    aeba_stream_if.sink                      i_in,
    aeba_stream_if.source                    o_out
);

    // Only the low SAMPLE_BITS bits of a sample count, and the field has 12.
    localparam int USE_W  = (SAMPLE_BITS < aeba_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                : aeba_pkg::SAMPLE_W;
    // The block sum stays below SAMPLES * 2**USE_W.
    localparam int SUM_W  = USE_W + $clog2(SAMPLES);
    localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int PROD_W = USE_W + aeba_pkg::TPT_W;
    // Rounded-up reciprocal of SAMPLES. With the shift below, the product of any
    // block sum and this constant gives exactly the truncated quotient.
    localparam int     RECIP_SH   = SUM_W + $clog2(SAMPLES);
    localparam int     RECIP_W    = SUM_W + 1;
    localparam longint RECIP_FULL = ((longint'(1) << RECIP_SH) + longint'(SAMPLES)
                                     - longint'(1)) / longint'(SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    // The divider is as wide as the position.
    localparam int DIV_W  = aeba_pkg::POS_W;
    localparam int DVS_W  = aeba_pkg::TDIV_W;
    localparam int ITER_W = $clog2(DIV_W);

    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES - 1);

    // Configuration registers.
    logic [aeba_pkg::TPT_W-1:0]  r_tpt;
    logic [aeba_pkg::TDIV_W-1:0] r_tdiv;

    // Accumulator and sequencer state.
    logic [SUM_W-1:0]            r_sum,   n_sum;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [aeba_pkg::PC_W-1:0]   r_pc,    n_pc;
    logic [ITER_W-1:0]           r_iter,  n_iter;

    // Datapath registers. The product register holds the reciprocal product of
    // the mean first and the tick product after it.
    logic [DIV_W-1:0]            r_quo,   n_quo;
    logic [DVS_W-1:0]            r_rem,   n_rem;
    logic [DVS_W-1:0]            r_dvs,   n_dvs;
    logic [USE_W-1:0]            r_mean,  n_mean;
    logic [PROD_W-1:0]           r_prod,  n_prod;
    logic [aeba_pkg::POS_W-1:0]  r_pos,   n_pos;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    aeba_pkg::t_out              r_out,       n_out;

    aeba_pkg::t_uop              uop;
    logic                        in_take;
    logic                        start;
    logic                        out_free;
    logic                        jump;
    logic [SUM_W-1:0]            sample_ext;
    logic [DVS_W:0]              trial;
    logic [DVS_W:0]              diff;
    logic                        ge;

    assign uop        = aeba_pkg::ucode(r_pc);
    assign i_in.ready = (r_pc == aeba_pkg::PC_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    assign start      = in_take && (r_count == LAST_COUNT);
    assign out_free   = !r_out_valid || o_out.ready;
    assign sample_ext = SUM_W'(i_in.data.sample[USE_W-1:0]);

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    // A zero divisor always succeeds, which leaves an all-ones quotient.
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_comb begin
        case (uop.cond)
            aeba_pkg::C_NEXT:     jump = 1'b0;
            aeba_pkg::C_NO_START: jump = !start;
            aeba_pkg::C_ITER:     jump = (r_iter != '0);
            aeba_pkg::C_OUT_FULL: jump = !out_free;
            default:              jump = 1'b0;
        endcase
        n_pc = jump ? uop.target : r_pc + 1'b1;
    end

    always_comb begin
        n_sum       = r_sum;
        n_count     = r_count;
        n_iter      = r_iter;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_mean      = r_mean;
        n_prod      = r_prod;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        if (in_take) begin
            n_sum   = r_sum + sample_ext;
            n_count = start ? '0 : r_count + 1'b1;
        end

        case (uop.act)
            aeba_pkg::A_MEAN_MUL: begin
                n_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
                n_sum  = '0;
            end
            aeba_pkg::A_DIV_STEP: begin
                n_quo  = {r_quo[DIV_W-2:0], ge};
                n_rem  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                n_iter = r_iter - 1'b1;
            end
            aeba_pkg::A_STORE_MEAN: begin
                n_mean = USE_W'(r_prod >> RECIP_SH);
            end
            aeba_pkg::A_MUL: begin
                n_prod = PROD_W'(r_mean) * PROD_W'(r_tpt);
            end
            aeba_pkg::A_LOAD_POS: begin
                n_pos  = aeba_pkg::POS_W'(r_prod >> SAMPLE_BITS);
                n_quo  = DIV_W'(aeba_pkg::POS_W'(r_prod >> SAMPLE_BITS));
                n_rem  = '0;
                n_dvs  = DVS_W'(r_tdiv);
                n_iter = ITER_W'(DIV_W - 1);
            end
            aeba_pkg::A_EMIT: begin
                if (out_free) begin
                    n_out.mean_sample    = aeba_pkg::MEAN_W'(r_mean);
                    n_out.position_ticks = r_pos;
                    n_out.divided_ticks  = r_quo[aeba_pkg::DIVIDED_W-1:0];
                    n_out_valid          = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpt       <= aeba_pkg::TPT_RESET;
            r_tdiv      <= aeba_pkg::TDIV_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_pc        <= aeba_pkg::PC_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aeba_pkg::CFG_TICKS_PER_TURN: r_tpt  <= i_cfg_data;
                    aeba_pkg::CFG_TICK_DIVIDER:   r_tdiv <= i_cfg_data[aeba_pkg::TDIV_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_pc        <= n_pc;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_mean <= n_mean;
        r_prod <= n_prod;
        r_pos  <= n_pos;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // The closing sample of a block starts the program and restarts the count.
    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_pc == aeba_pkg::PC_MEAN_MUL) && (r_count == '0))
        else $error("block end did not start the result program");

    // The divide loop leaves exactly when its step count runs out.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == aeba_pkg::PC_DIV_POS) && (r_iter == '0) |=> (r_pc == aeba_pkg::PC_WAIT_OUT))
        else $error("divide loop left at the wrong step");

    // The emit step loads a result whenever the output register is free.
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == aeba_pkg::PC_EMIT) && out_free |=> o_out.valid && (r_pc == aeba_pkg::PC_IDLE))
        else $error("emit step did not present a result");

    // The sum is cleared once the program has taken it.
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == aeba_pkg::PC_MEAN_MUL) |=> (r_sum == '0))
        else $error("block sum not cleared after load");
`endif

endmodule

// ----- tb/sv/analog_encoder_block_average_test.sv -----
// Self-checking testbench of the encoder block averager with a predicting scoreboard.

// Scoreboard: predicts one result per block of samples and compares the block's results
// with those predictions in order.
class block_average_scoreboard;
    localparam int BLOCK_LEN    = aeba_pkg::SAMPLES_DEF;
    localparam int SAMPLE_SHIFT = aeba_pkg::SAMPLE_BITS_DEF;

    logic [aeba_pkg::TPT_W-1:0]  ticks_per_turn;
    logic [aeba_pkg::TDIV_W-1:0] tick_divider;
    logic [17:0]                 block_sum;
    int unsigned                 block_fill;
    aeba_pkg::t_out              block_results_q[$];
    int                          errors;

    function new();
        ticks_per_turn = aeba_pkg::TPT_RESET;
        tick_divider   = aeba_pkg::TDIV_RESET;
        block_sum      = '0;
        block_fill     = 0;
        errors         = 0;
    endfunction

    task report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Unknown indexes are dropped, and each register keeps only its own width.
    function void write_register(input logic [aeba_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [aeba_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            aeba_pkg::CFG_TICKS_PER_TURN: ticks_per_turn = data[aeba_pkg::TPT_W-1:0];
            aeba_pkg::CFG_TICK_DIVIDER:   tick_divider   = data[aeba_pkg::TDIV_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_sample(input aeba_pkg::t_in item);
        aeba_pkg::t_out res;
        logic [63:0]    product;
        logic [31:0]    pos;
        block_sum  = block_sum + 18'(item.sample);
        block_fill = block_fill + 1;
        if (block_fill == BLOCK_LEN) begin
            res.mean_sample    = 12'(block_sum / BLOCK_LEN);
            product            = 64'(res.mean_sample) * 64'(ticks_per_turn);
            pos                = 32'(product >> SAMPLE_SHIFT);
            res.position_ticks = pos;
            if (tick_divider == '0) begin
                res.divided_ticks = 16'hFFFF;
            end else begin
                res.divided_ticks = 16'(pos / 32'(tick_divider));
            end
            block_results_q.push_back(res);
            block_sum  = '0;
            block_fill = 0;
        end
    endfunction

    task check_result(input aeba_pkg::t_out got);
        aeba_pkg::t_out want;
        if (block_results_q.size() == 0) begin
            report($sformatf("unexpected result %0h", got));
        end else begin
            want = block_results_q.pop_front();
            if (got.mean_sample !== want.mean_sample)
                report($sformatf("mean_sample expected %0h got %0h",
                                 want.mean_sample, got.mean_sample));
            if (got.position_ticks !== want.position_ticks)
                report($sformatf("position_ticks expected %0h got %0h",
                                 want.position_ticks, got.position_ticks));
            if (got.divided_ticks !== want.divided_ticks)
                report($sformatf("divided_ticks expected %0h got %0h",
                                 want.divided_ticks, got.divided_ticks));
        end
    endtask

    function int pending();
        return block_results_q.size();
    endfunction

    task check_leftover();
        if (block_results_q.size() != 0)
            report($sformatf("%0d results never arrived", block_results_q.size()));
    endtask
endclass

module analog_encoder_block_average_test;

    localparam int BLOCK_LEN        = aeba_pkg::SAMPLES_DEF;
    // The closing sample keeps the sequencer busy until its result is emitted, so this many
    // quiet cycles after the last result leave the block fully idle.
    localparam int SETTLE_CYCLES    = 100;
    // Long enough for a waiting result, a full next block and a second stalled emit.
    localparam int RECV_HOLD_CYCLES = 600;
    localparam int NUM_PHASES       = 6;

    // Register indexes that the block does not decode; writes to them must be dropped.
    localparam logic [aeba_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [aeba_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [aeba_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [aeba_pkg::CFG_DATA_W-1:0] i_cfg_data;

    aeba_stream_if #(.T(aeba_pkg::t_in))  in_ch ();
    aeba_stream_if #(.T(aeba_pkg::t_out)) out_ch ();

    analog_encoder_block_average uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    block_average_scoreboard sb;

    // Idle rates in percent of cycles for each side, set per phase by the main process.
    int send_idle_pct;
    int recv_idle_pct;
    // Each increment asks the receiver process for one long hold-off.
    int hold_requests;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // The timeout lies far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Everything is sampled at the rising edge, where the inputs driven at the falling
    // edge are stable and the block's registered outputs still hold their old values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_register(i_cfg_index, i_cfg_data);
            if (in_ch.valid && in_ch.ready)
                sb.note_sample(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data);
        end
    end

    // Receiver: random back-pressure, or a long hold-off counted down here when the
    // main process asks for one.
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = RECV_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one sample, after a random number of idle cycles, and returns at the falling
    // edge after its transaction. Valid stays high so that back-to-back samples keep it up.
    task automatic send_sample(input logic [aeba_pkg::SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data.sample <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops offering samples until every predicted result has come and the sequencer
    // has had time to finish; register writes are safe afterwards.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write; the enable is dropped and held low before the task returns, so that back-to-back
    // writes never lower and raise it in the same step.
    task automatic write_register(input logic [aeba_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [aeba_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly uniform samples, with a share pinned at the rails or near full scale so that
    // block means also reach the top of the range.
    function automatic logic [aeba_pkg::SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return '1;
        else if (pick < 35)
            return aeba_pkg::SAMPLE_W'($urandom_range(4095, 3968));
        else
            return aeba_pkg::SAMPLE_W'($urandom_range(4095));
    endfunction

    initial begin
        int                          burst;
        logic [31:0]                 junk;
        logic [aeba_pkg::TPT_W-1:0]  tpt_val;
        logic [aeba_pkg::TDIV_W-1:0] div_val;

        sb = new();
        send_idle_pct     = 32;
        recv_idle_pct     = 48;
        hold_requests     = 0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.data.sample = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. The largest tick count with a divider of one whose upper
        // junk bits must be dropped, plus writes to undecoded indexes that change nothing.
        write_register(aeba_pkg::CFG_TICKS_PER_TURN, 32'hFFFF_FFFF);
        write_register(aeba_pkg::CFG_TICK_DIVIDER, 32'hABCD_EF01);
        write_register(CFG_UNUSED_A, $urandom());
        write_register(CFG_UNUSED_B, $urandom());

        // A block at full scale gives the largest mean and a position that wraps in
        // the 16-bit divided output.
        repeat (BLOCK_LEN) send_sample('1);

        // Half a block of zeros, then new registers in the middle of the block: they
        // must apply to the block that ends next. The divider reads zero once its
        // junk upper bits are dropped.
        repeat (8) send_sample('0);
        drain_results();
        write_register(aeba_pkg::CFG_TICK_DIVIDER, 32'h0000_5A00);
        write_register(aeba_pkg::CFG_TICKS_PER_TURN, 32'd4096);
        for (int k = 8; k < BLOCK_LEN; k++)
            send_sample((k % 2 == 0) ? 12'hA5A : 12'h5A5);
        drain_results();

        // Random part in phases: receiver-heavy idling, then sender-heavy, then none.
        // Each phase opens on an idle block with a new pair of register values, and
        // its length is not always a multiple of the block, so later writes can land mid-block too.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 48;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            case (ph)
                0: begin
                    tpt_val = '0;
                    div_val = 8'd255;
                end
                1: begin
                    tpt_val = '1;
                    div_val = 8'd1;
                end
                3: begin
                    tpt_val = aeba_pkg::TPT_RESET;
                    div_val = 8'($urandom_range(255, 1));
                end
                4: begin
                    tpt_val = $urandom();
                    div_val = '0;
                end
                default: begin
                    tpt_val = $urandom();
                    div_val = 8'($urandom_range(255));
                end
            endcase
            junk = $urandom();
            write_register(aeba_pkg::CFG_TICKS_PER_TURN, tpt_val);
            write_register(aeba_pkg::CFG_TICK_DIVIDER, {junk[31:8], div_val});
            if (ph == 2)
                write_register(CFG_UNUSED_B, junk);

            // With the sender at full rate, a long receiver hold-off lets a result wait,
            // the next block fill behind it and the input stall on the second emit.
            if (ph == 4)
                hold_requests++;

            burst = $urandom_range(100, 80);
            repeat (burst) send_sample(random_sample());
            drain_results();
        end

        sb.check_leftover();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
